### hw/rtl/deficit_round_robin_flow_queue_assert.svh
// Assertion helpers for the flow queue scheduler; expect clk and arst_n in scope.
`ifndef DEFICIT_ROUND_ROBIN_FLOW_QUEUE_ASSERT_SVH
`define DEFICIT_ROUND_ROBIN_FLOW_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DFQ_ASSERT_IMPLY(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define DFQ_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DFQ_ASSERT_IMPLY(label, ante, cons, msg)
`define DFQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/dfq_pkg.sv
package dfq_pkg;

	localparam int FLOWS_DEF        = 16;
	localparam int PER_FLOW_DEF     = 64;
	localparam int MAX_PKT_DEF      = 2048;
	localparam int DEF_W            = 20;
	localparam int DESC_W           = 28;
	localparam logic [5:0] MAX_DROPS = 6'd63;
	localparam logic [15:0] QUANTUM_RST  = 16'd1500;
	localparam logic [19:0] CAPACITY_RST = 20'd65536;

	// command codes
	localparam logic [1:0] OP_ENQ    = 2'd0;
	localparam logic [1:0] OP_SEND   = 2'd1;
	localparam logic [1:0] OP_CREDIT = 2'd2;

	// result kinds
	localparam logic [2:0] K_ACCEPTED = 3'd0;
	localparam logic [2:0] K_SENT     = 3'd1;
	localparam logic [2:0] K_DROPPED  = 3'd2;
	localparam logic [2:0] K_NOTHING  = 3'd3;
	localparam logic [2:0] K_GRANTED  = 3'd4;
	localparam logic [2:0] K_REFUSED  = 3'd5;

	// configuration register indexes
	localparam logic CFG_QUANTUM  = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  flow_index;
		logic [11:0] byte_count;
		logic [15:0] packet_tag;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  out_flow;
		logic [11:0] out_size;
		logic [15:0] out_tag;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		ALU_ADD20,
		ALU_ADD32,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENQ,
		S_ENQ_FIRST,
		S_CAP,
		S_SCAN,
		S_PICK,
		S_DROP,
		S_SEND_CHK,
		S_SEND_CMP,
		S_ADV,
		S_SWEEP,
		S_ADD_DEF,
		S_CRED,
		S_FIN
	} state_t;

endpackage

### hw/rtl/dfq_ram.sv
module dfq_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/dfq_alu.sv
module dfq_alu (
	input  logic             [31:0] a,
	input  logic             [31:0] b,
	input  dfq_pkg::alu_op_t        op,
	output logic             [31:0] y,
	output logic                    ge
);
	import dfq_pkg::*;

	logic [32:0] sum;

	// one adder, saturating at the deficit or credit ceiling, or a plain subtract
	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		ge  = (a >= b);
		unique case (op)
			ALU_ADD20: y = (sum > 33'h0_000F_FFFF) ? 32'h000F_FFFF : sum[31:0];
			ALU_ADD32: y = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			ALU_SUB:   y = a - b;
			default:   y = a - b;
		endcase
	end
endmodule

### hw/rtl/deficit_round_robin_flow_queue.sv
// Per-flow packet scheduler: deficit round robin with longest-flow tail drop.
// Command channel: cmd is taken when start is high and busy is low; busy
// stays high until every result of the command has been issued.
// Results: result is valid for exactly one cycle when result_valid is high;
// result.last marks the final one. The receiver cannot stall the block.
// Configuration: cfg_valid/cfg_ready write quantum (index 0) or buffer
// capacity (index 1); cfg_ready is always high; write only while idle.
// Timing: one sequencer step per cycle around one shared adder/comparator.
// Credit check: one compare, then finish. Enqueue: accept or drop, a deficit
// grant when the buffer was empty, a capacity check, and per tail drop a
// longest-flow scan (one flow per cycle), a pick and a drop. Send: a check and
// a compare that sends if the current head fits; each flow skipped adds an
// advance and a deficit add; a round wrap sweeps credit one flow per cycle.
// Results wait for the next one or the finish; the last goes as busy falls.
// Reset: all flows inactive and empty, quantum 1500, capacity 65536; the
// descriptor memory is not cleared, flow counts gate every read of it.
`include "deficit_round_robin_flow_queue_assert.svh"
module deficit_round_robin_flow_queue #(
	parameter int FLOWS            = dfq_pkg::FLOWS_DEF,
	parameter int PER_FLOW_DEPTH   = dfq_pkg::PER_FLOW_DEF,
	parameter int MAX_PACKET_BYTES = dfq_pkg::MAX_PKT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dfq_pkg::cmd_t cmd,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [19:0]   cfg_data,
	output logic          result_valid,
	output dfq_pkg::res_t result
);
	import dfq_pkg::*;

	localparam int FW     = $clog2(FLOWS);
	localparam int HW     = $clog2(PER_FLOW_DEPTH);
	localparam int CW     = $clog2(PER_FLOW_DEPTH + 1);
	localparam int BW     = $clog2(PER_FLOW_DEPTH * 4095 + 1);
	localparam int TW     = $clog2(FLOWS * PER_FLOW_DEPTH * 4095 + 1);
	localparam int SLOTS  = FLOWS * PER_FLOW_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic [HW-1:0]    head_q  [FLOWS];
	logic [CW-1:0]    cnt_q   [FLOWS];
	logic [BW-1:0]    bytes_q [FLOWS];
	logic [DEF_W-1:0] def_q   [FLOWS];
	logic [31:0]      cred_q  [FLOWS];
	logic [FLOWS-1:0] act_q;
	logic [FW-1:0]    cur_q;
	logic [TW-1:0]    total_q;
	logic [15:0]      quantum_q;
	logic [19:0]      cap_q;

	logic [FW-1:0] scan_q, best_q;
	logic [BW-1:0] bestb_q;
	logic [5:0]    drops_q;
	logic          pend_v_q;
	res_t          pend_q;

	logic [FW-1:0]     f_in;
	logic              fl_ok, enq_bad;
	logic [15:0]       q_eff;
	logic [FLOWS-1:0]  clr_mask, act_eff;
	logic              lo_found, nxt_found;
	logic [FW-1:0]     lo_idx, nxt_idx;
	logic              put, fin;
	res_t              put_r;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [DESC_W-1:0] rdata;
	logic [11:0]       psz;
	logic [31:0]       alu_a, alu_b, alu_y;
	alu_op_t           alu_op;
	logic              alu_ge;

	function automatic logic [HW-1:0] wrap_pos(input logic [HW+1:0] s);
		logic [HW+1:0] r;
		r = (s >= (HW+2)'(PER_FLOW_DEPTH)) ? s - (HW+2)'(PER_FLOW_DEPTH) : s;
		return r[HW-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] slot(input logic [FW-1:0] f, input logic [HW-1:0] p);
		return ADDR_W'(ADDR_W'(f) * ADDR_W'(PER_FLOW_DEPTH) + ADDR_W'(p));
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign f_in      = FW'(cmd_q.flow_index);
	assign fl_ok     = (32'(cmd_q.flow_index) < FLOWS);
	assign q_eff     = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
	assign psz       = rdata[11:0];
	assign enq_bad   = !fl_ok || (32'(cmd_q.byte_count) > MAX_PACKET_BYTES)
		|| (32'(cnt_q[f_in]) >= PER_FLOW_DEPTH);

	// an empty current flow leaves the active set while skipping it
	assign clr_mask = (state_q == S_ADV && cnt_q[cur_q] == '0)
		? ({{(FLOWS-1){1'b0}}, 1'b1} << cur_q) : '0;
	assign act_eff  = act_q & ~clr_mask;

	// lowest active flow, and next active flow above the current one
	always_comb begin
		lo_found  = 1'b0;
		lo_idx    = '0;
		nxt_found = 1'b0;
		nxt_idx   = '0;
		for (int i = FLOWS - 1; i >= 0; i--) begin
			if (act_eff[i]) begin
				lo_found = 1'b1;
				lo_idx   = FW'(i);
				if (FW'(i) > cur_q) begin
					nxt_found = 1'b1;
					nxt_idx   = FW'(i);
				end
			end
		end
	end

	// descriptor memory ports
	assign waddr = slot(f_in, wrap_pos((HW+2)'(head_q[f_in]) + (HW+2)'(cnt_q[f_in])));
	always_comb begin
		if (state_q == S_PICK) begin
			raddr = slot(best_q, wrap_pos((HW+2)'(head_q[best_q]) + (HW+2)'(cnt_q[best_q])
				- (HW+2)'(1)));
		end else begin
			raddr = slot(cur_q, head_q[cur_q]);
		end
	end

	dfq_ram #(
		.WIDTH(DESC_W),
		.DEPTH(SLOTS)
	) u_desc_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({cmd_q.packet_tag, cmd_q.byte_count}),
		.raddr(raddr),
		.rdata(rdata)
	);

	dfq_alu u_alu (
		.a (alu_a),
		.b (alu_b),
		.op(alu_op),
		.y (alu_y),
		.ge(alu_ge)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		put     = 1'b0;
		put_r   = '0;
		fin     = 1'b0;
		we      = 1'b0;
		alu_a   = 32'(def_q[cur_q]);
		alu_b   = 32'(q_eff);
		alu_op  = ALU_ADD20;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd.op)
						OP_ENQ:    state_d = S_ENQ;
						OP_SEND:   state_d = S_SEND_CHK;
						OP_CREDIT: state_d = S_CRED;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_ENQ: begin
				put   = 1'b1;
				put_r = '{kind: enq_bad ? K_DROPPED : K_ACCEPTED, out_flow: cmd_q.flow_index,
					out_size: cmd_q.byte_count, out_tag: cmd_q.packet_tag, last: 1'b0};
				we    = !enq_bad;
				state_d = (!enq_bad && total_q == '0) ? S_ENQ_FIRST : S_CAP;
			end
			S_ENQ_FIRST: begin
				alu_a   = 32'(def_q[lo_idx]);
				state_d = S_CAP;
			end
			S_CAP: begin
				if (32'(total_q) > 32'(cap_q) && drops_q != MAX_DROPS) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				if (scan_q == FW'(FLOWS - 1)) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				state_d = (bestb_q == '0 || cnt_q[best_q] == '0) ? S_FIN : S_DROP;
			end
			S_DROP: begin
				put   = 1'b1;
				put_r = '{kind: K_DROPPED, out_flow: 4'(best_q), out_size: psz,
					out_tag: rdata[27:12], last: 1'b0};
				state_d = S_CAP;
			end
			S_SEND_CHK: begin
				state_d = (act_q[cur_q] && cnt_q[cur_q] != '0) ? S_SEND_CMP : S_ADV;
			end
			S_SEND_CMP: begin
				alu_b  = 32'(psz);
				alu_op = ALU_SUB;
				if (alu_ge) begin
					put   = 1'b1;
					put_r = '{kind: K_SENT, out_flow: 4'(cur_q), out_size: psz,
						out_tag: rdata[27:12], last: 1'b0};
					state_d = S_FIN;
				end else begin
					state_d = S_ADV;
				end
			end
			S_ADV: begin
				if (nxt_found) begin
					state_d = S_ADD_DEF;
				end else if (lo_found) begin
					state_d = S_SWEEP;
				end else begin
					put     = 1'b1;
					put_r   = '{kind: K_NOTHING, default: '0};
					state_d = S_FIN;
				end
			end
			S_SWEEP: begin
				alu_a  = cred_q[scan_q];
				alu_op = ALU_ADD32;
				if (scan_q == FW'(FLOWS - 1)) begin
					state_d = S_ADD_DEF;
				end
			end
			S_ADD_DEF: begin
				state_d = S_SEND_CHK;
			end
			S_CRED: begin
				alu_a  = cred_q[f_in];
				alu_b  = 32'(cmd_q.byte_count);
				alu_op = ALU_SUB;
				put    = 1'b1;
				put_r  = '{kind: (fl_ok && act_q[f_in] && !alu_ge) ? K_REFUSED : K_GRANTED,
					out_flow: cmd_q.flow_index, out_size: cmd_q.byte_count,
					out_tag: 16'd0, last: 1'b0};
				state_d = S_FIN;
			end
			S_FIN: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// flow state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLOWS; i++) begin
				head_q[i]  <= '0;
				cnt_q[i]   <= '0;
				bytes_q[i] <= '0;
				def_q[i]   <= '0;
				cred_q[i]  <= '0;
			end
			act_q     <= '0;
			cur_q     <= '0;
			total_q   <= '0;
			quantum_q <= QUANTUM_RST;
			cap_q     <= CAPACITY_RST;
			drops_q   <= '0;
			scan_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_QUANTUM:  quantum_q <= cfg_data[15:0];
					CFG_CAPACITY: cap_q     <= cfg_data;
					default:      cap_q     <= cfg_data;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						drops_q <= '0;
					end
				end
				S_ENQ: begin
					if (!enq_bad) begin
						if (!act_q[f_in]) begin
							act_q[f_in]  <= 1'b1;
							def_q[f_in]  <= '0;
							cred_q[f_in] <= '0;
						end
						cnt_q[f_in]   <= cnt_q[f_in] + CW'(1);
						bytes_q[f_in] <= bytes_q[f_in] + BW'(cmd_q.byte_count);
						total_q       <= total_q + TW'(cmd_q.byte_count);
					end
				end
				S_ENQ_FIRST: begin
					cur_q         <= lo_idx;
					def_q[lo_idx] <= alu_y[DEF_W-1:0];
				end
				S_CAP: begin
					scan_q <= '0;
				end
				S_SCAN: begin
					scan_q <= scan_q + FW'(1);
				end
				S_PICK: begin
					if (bestb_q != '0 && cnt_q[best_q] != '0) begin
						cnt_q[best_q] <= cnt_q[best_q] - CW'(1);
					end
				end
				S_DROP: begin
					bytes_q[best_q] <= bytes_q[best_q] - BW'(psz);
					total_q         <= total_q - TW'(psz);
					drops_q         <= drops_q + 6'd1;
				end
				S_SEND_CMP: begin
					if (alu_ge) begin
						def_q[cur_q]   <= alu_y[DEF_W-1:0];
						head_q[cur_q]  <= wrap_pos((HW+2)'(head_q[cur_q]) + (HW+2)'(1));
						cnt_q[cur_q]   <= cnt_q[cur_q] - CW'(1);
						bytes_q[cur_q] <= bytes_q[cur_q] - BW'(psz);
						total_q        <= total_q - TW'(psz);
					end
				end
				S_ADV: begin
					if (cnt_q[cur_q] == '0) begin
						act_q[cur_q]  <= 1'b0;
						def_q[cur_q]  <= '0;
						cred_q[cur_q] <= '0;
						head_q[cur_q] <= '0;
					end
					if (nxt_found) begin
						cur_q <= nxt_idx;
					end else if (lo_found) begin
						cur_q  <= lo_idx;
						scan_q <= '0;
					end
				end
				S_SWEEP: begin
					if (act_q[scan_q]) begin
						cred_q[scan_q] <= alu_y;
					end
					scan_q <= scan_q + FW'(1);
				end
				S_ADD_DEF: begin
					def_q[cur_q] <= alu_y[DEF_W-1:0];
				end
				S_CRED: begin
					if (fl_ok && act_q[f_in] && alu_ge) begin
						cred_q[f_in] <= alu_y;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers: command latch and longest-flow search
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == S_CAP) begin
			best_q  <= '0;
			bestb_q <= '0;
		end else if (state_q == S_SCAN && bytes_q[scan_q] > bestb_q) begin
			best_q  <= scan_q;
			bestb_q <= bytes_q[scan_q];
		end
	end

	// one result held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (put) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					result_valid <= 1'b1;
				end
			end
			if (fin) begin
				pend_v_q <= 1'b0;
				if (pend_v_q) begin
					result_valid <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			pend_q <= put_r;
			result <= '{kind: pend_q.kind, out_flow: pend_q.out_flow,
				out_size: pend_q.out_size, out_tag: pend_q.out_tag, last: 1'b0};
		end
		if (fin) begin
			result <= '{kind: pend_q.kind, out_flow: pend_q.out_flow,
				out_size: pend_q.out_size, out_tag: pend_q.out_tag, last: 1'b1};
		end
	end

	`DFQ_ASSERT_IMPLY(a_idle_no_pending, !busy, !pend_v_q, "result pending while idle")
	`DFQ_ASSERT_NEXT(a_last_then_quiet, result_valid && result.last, !result_valid, "after last")
	`DFQ_ASSERT_IMPLY(a_drop_limit, state_q == S_DROP, drops_q < MAX_DROPS, "drop limit")
	`DFQ_ASSERT_IMPLY(a_send_active, state_q == S_SEND_CMP, act_q[cur_q] && cnt_q[cur_q] != '0, "empty")
endmodule
